/* rtl/mtf_pkg.sv */
// ============================================================================
// mtf_pkg: shared types and codes for the max tracking FIFO
// Operation codes, status codes and the sequencer state type.
// ============================================================================
package mtf_pkg;

    // Fixed width of the value fields on the ports.
    localparam int FIELD_W = 32;

    typedef logic [1:0] op_code_t;
    typedef logic [1:0] status_t;

    localparam op_code_t OP_PUSH = 2'd0;
    localparam op_code_t OP_POP  = 2'd1;
    localparam op_code_t OP_PEEK = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_UNDERFLOW = 2'd1;
    localparam status_t ST_OVERFLOW  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FRONT,
        S_SCAN,
        S_DONE
    } mtf_state_t;

endpackage

/* rtl/mtf_ram.sv */
// ============================================================================
// mtf_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module mtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/max_tracking_fifo.sv */
// ============================================================================
// max_tracking_fifo: FIFO of signed words that tracks its largest entry
// Ring buffer in a RAM with a small sequencer that rescans for the maximum.
// ============================================================================
// Usage:
// Each input beat carries an operation (push, pop or peek) and a value that
// is used only by a push. Every input beat produces exactly one output beat
// with the front entry, the maximum, the entry count, an empty flag and a
// status (ok, pop on empty ignored, push on full ignored). Code 3 acts as a
// peek. Front and maximum read 0 while the queue is empty.
// Flow: the block takes one input beat at a time. A push, a peek, a
// rejected operation or a pop that empties the queue goes from acceptance
// through the execute and done states to a valid output beat. A pop that
// leaves entries also passes through the front state, since the new front
// entry comes from the RAM read port. A pop that removes the current maximum
// rescans the remaining entries through the single RAM read port and the
// shared signed comparator, one entry per cycle. The next input beat is
// accepted once the sequencer is idle again. Reset clears the indexes,
// the count and the maximum; the RAM contents are not cleared, since no
// entry is read before it is written. When the receiver stalls, the
// finished beat waits in the output register. The next input beat may
// still be accepted and processed, but its result is held in the
// sequencer, and no further beat is taken, until that register is free.
// ============================================================================
module max_tracking_fifo #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mtf_pkg::op_code_t                   operation,
    input  logic signed [mtf_pkg::FIELD_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mtf_pkg::FIELD_W-1:0]  front_value,
    output logic signed [mtf_pkg::FIELD_W-1:0]  max_value,
    output logic [$clog2(DEPTH+1)-1:0]          count,
    output logic                                is_empty,
    output mtf_pkg::status_t                    status
);

    import mtf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer and queue state.
    mtf_state_t            state_reg, state_next;
    op_code_t              op_reg, op_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] max_reg, max_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    status_t               status_reg, status_next;

    // Rescan bookkeeping: next slot to read and reads still to be issued.
    logic [AW-1:0]         scan_addr_reg, scan_addr_next;
    logic [CW-1:0]         scan_left_reg, scan_left_next;
    logic                  rescan_reg, rescan_next;

    // Output register.
    logic                  out_valid_reg;
    logic [FIELD_W-1:0]    out_front_reg;
    logic [FIELD_W-1:0]    out_max_reg;
    logic [CW-1:0]         out_count_reg;
    logic                  out_empty_reg;
    status_t               out_status_reg;

    // RAM ports.
    logic                  wr_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic [DATA_WIDTH-1:0] value_conv;
    logic [FIELD_W-1:0]    front_ext;
    logic [FIELD_W-1:0]    max_ext;
    logic                  out_load;
    logic [DATA_WIDTH-1:0] cmp_operand;
    logic                  cmp_greater;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        if (idx == AW'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // The input word is sign-extended or truncated to the stored width, and
    // stored words are zero-extended or truncated back to the port width.
    generate
        if (DATA_WIDTH >= FIELD_W)
        begin : g_wide
            assign value_conv = DATA_WIDTH'(value);
            assign front_ext  = front_reg[FIELD_W-1:0];
            assign max_ext    = max_reg[FIELD_W-1:0];
        end
        else
        begin : g_narrow
            assign value_conv = value[DATA_WIDTH-1:0];
            assign front_ext  = {{(FIELD_W - DATA_WIDTH){1'b0}}, front_reg};
            assign max_ext    = {{(FIELD_W - DATA_WIDTH){1'b0}}, max_reg};
        end
    endgenerate

    // One signed comparator against the running maximum: it sees the pushed
    // word while executing and the RAM read data during a rescan.
    assign cmp_operand = (state_reg == S_EXEC) ? val_reg : rd_data;
    assign cmp_greater = $signed(cmp_operand) > $signed(max_reg);

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    mtf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (tail_reg),
        .wdata (val_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_POP && count_reg > CW'(1))
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FRONT:
            begin
                if (rescan_reg && scan_left_reg != '0)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_left_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control.
    always_comb
    begin
        op_next        = op_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        max_next       = max_reg;
        front_next     = front_reg;
        status_next    = status_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        rescan_next    = rescan_reg;
        wr_en          = 1'b0;
        rd_addr        = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = operation;
                    val_next = value_conv;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            tail_next  = next_slot(tail_reg);
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0)
                            begin
                                front_next = val_reg;
                            end
                            if (count_reg == '0 || cmp_greater)
                            begin
                                max_next = val_reg;
                            end
                        end
                    end
                    OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            // The front entry leaving is held in front_reg.
                            head_next      = next_slot(head_reg);
                            count_next     = count_reg - 1'b1;
                            rd_addr        = next_slot(head_reg);
                            scan_addr_next = next_slot(next_slot(head_reg));
                            scan_left_next = count_reg - CW'(2);
                            rescan_next    = (front_reg == max_reg);
                            if (count_reg == CW'(1) && front_reg == max_reg)
                            begin
                                max_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FRONT:
            begin
                front_next = rd_data;
                if (rescan_reg)
                begin
                    max_next = rd_data;
                    if (scan_left_reg != '0)
                    begin
                        rd_addr        = scan_addr_reg;
                        scan_addr_next = next_slot(scan_addr_reg);
                        scan_left_next = scan_left_reg - 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (cmp_greater)
                begin
                    max_next = rd_data;
                end
                if (scan_left_reg != '0)
                begin
                    rd_addr        = scan_addr_reg;
                    scan_addr_next = next_slot(scan_addr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            max_reg       <= '0;
            rescan_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            max_reg    <= max_next;
            rescan_reg <= rescan_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        front_reg     <= front_next;
        status_reg    <= status_next;
        scan_addr_reg <= scan_addr_next;
        scan_left_reg <= scan_left_next;
        if (out_load)
        begin
            out_front_reg  <= (count_reg != '0) ? front_ext : '0;
            out_max_reg    <= (count_reg != '0) ? max_ext : '0;
            out_count_reg  <= count_reg;
            out_empty_reg  <= (count_reg == '0);
            out_status_reg <= status_reg;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign front_value = out_front_reg;
    assign max_value   = out_max_reg;
    assign count       = out_count_reg;
    assign is_empty    = out_empty_reg;
    assign status      = out_status_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The stored count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds DEPTH");

    // A rejected push is reported only when the queue is full.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OVERFLOW |-> count == CW'(DEPTH))
        else $error("overflow reported on a queue that is not full");

    // An empty queue reports zero for the front entry and the maximum.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> front_value == '0 && max_value == '0 && count == '0)
        else $error("empty queue reports nonzero front or maximum");

    // A new beat is never taken right after one was accepted.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an operation is in progress");

endmodule
